### hdl/ajgma_pkg.sv
// Shared widths, register indexes, reset values and outcome codes of the angle smoother.
package ajgma_pkg;

  localparam int THR_W      = 16;
  localparam int SWC_W      = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SMOOTH_W   = 16;
  localparam int OUTCOME_W  = 2;

  localparam logic [THR_W-1:0] THR_RESET = 16'd2731;
  localparam logic [SWC_W-1:0] SWC_RESET = 3'd3;

  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t CFG_JUMP_THRESHOLD = 1'b0;
  localparam cfg_index_t CFG_SWITCH_COUNT   = 1'b1;

  typedef enum logic [OUTCOME_W-1:0] {
    OC_FIRST  = 2'd0,
    OC_ACCEPT = 2'd1,
    OC_HOLD   = 2'd2,
    OC_SWITCH = 2'd3
  } outcome_t;

endpackage

### hdl/ajgma_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
module ajgma_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/ajgma_div.sv
// Restoring serial divider, one quotient bit per cycle.
module ajgma_div #(
  parameter int DVD_W = 20,
  parameter int DVS_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_r, q_r[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
      rem_nxt  = '0;
      q_nxt    = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the low DVS_W bits hold it
      rem_nxt = fits ? DVS_W'(rem_sh - {1'b0, dvs_r}) : DVS_W'(rem_sh);
      q_nxt   = {q_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

### hdl/angle_jump_gated_moving_average.sv
// Top level: gated moving average of angles with candidate window switch.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in      | input     | in_valid/in_stall  | in_angle_in
//  out     | output    | out_valid/out_stall| out_smoothed_angle, out_outcome
//  cfg     | input     | cfg_wr_en          | cfg_index, cfg_data
//
// One item at a time. First sample or held candidate: evaluate, then result.
// Accepted angle: evaluate, evict the oldest entry if full, then the serial mean divider
// divides the TOT_W-bit total, TOT_W = ANGLE_BITS+clog2(WINDOW_DEPTH+1), 20 at defaults.
// Window switch: each held candidate is read, then copied through the RAM read port.
// in_stall is high while an item is at work and during reset (rst_n, synchronous).
// A finished result sits in the output register; out_stall only holds the result
// stage once a second result is ready.
module angle_jump_gated_moving_average #(
  parameter int WINDOW_DEPTH    = 8,
  parameter int CANDIDATE_DEPTH = 4,
  parameter int ANGLE_BITS      = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ANGLE_BITS-1:0]           in_angle_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ajgma_pkg::SMOOTH_W-1:0]  out_smoothed_angle,
  output logic [ajgma_pkg::OUTCOME_W-1:0] out_outcome,
  input  logic                            cfg_wr_en,
  input  ajgma_pkg::cfg_index_t           cfg_index,
  input  logic [ajgma_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int FW    = $clog2(WINDOW_DEPTH + 1);
  localparam int SW    = WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1;
  localparam int PW    = FW + 1;
  localparam int TOT_W = ANGLE_BITS + FW;
  localparam int CF_W  = $clog2(CANDIDATE_DEPTH + 1);
  localparam int CIW   = CANDIDATE_DEPTH > 1 ? $clog2(CANDIDATE_DEPTH) : 1;
  localparam int CW    = $clog2(CANDIDATE_DEPTH + WINDOW_DEPTH + 1);
  localparam int NW    = CF_W > ajgma_pkg::SWC_W ? CF_W : ajgma_pkg::SWC_W;
  localparam int DW    = ANGLE_BITS > ajgma_pkg::THR_W ? ANGLE_BITS : ajgma_pkg::THR_W;

  localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_EVICT, S_SW_RD, S_SW_WR, S_DIV_GO, S_DIV_WAIT, S_RESULT
  } state_t;

  state_t                         state_r, state_nxt;
  logic [ANGLE_BITS-1:0]          a_r, a_nxt;
  logic [ANGLE_BITS-1:0]          mean_r, mean_nxt;
  logic [FW-1:0]                  wfill_r, wfill_nxt;
  logic [SW-1:0]                  oldest_r, oldest_nxt;
  logic [TOT_W-1:0]               total_r, total_nxt;
  logic [CF_W-1:0]                cfill_r, cfill_nxt;
  logic [CIW-1:0]                 idx_r, idx_nxt;
  logic [SW-1:0]                  ws_r, ws_nxt;
  logic [ajgma_pkg::THR_W-1:0]    thr_r, thr_nxt;
  logic [ajgma_pkg::SWC_W-1:0]    swc_r, swc_nxt;
  ajgma_pkg::outcome_t            oc_r, oc_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [ajgma_pkg::SMOOTH_W-1:0] out_mean_r, out_mean_nxt;
  ajgma_pkg::outcome_t            out_oc_r, out_oc_nxt;

  logic                  win_we;
  logic [SW-1:0]         win_waddr;
  logic [ANGLE_BITS-1:0] win_wdata;
  logic [ANGLE_BITS-1:0] win_q;
  logic                  cand_we;
  logic [ANGLE_BITS-1:0] cand_q;

  logic                  div_start;
  logic                  div_done;
  logic [TOT_W-1:0]      div_quot;

  logic [ANGLE_BITS-1:0] diff, diff_neg, wrap_dist;
  logic                  in_gate;
  logic [PW-1:0]         push_sum;
  logic [SW-1:0]         push_slot;
  logic                  win_full;
  logic                  cand_full;
  logic [CF_W-1:0]       new_cf;
  logic [NW-1:0]         need;
  logic [SW-1:0]         oldest_inc;
  logic [SW-1:0]         ws_inc;
  logic                  keep_cand;
  logic                  last_cand;
  logic                  cf_ge_wd;
  logic                  out_free;

  // shortest wrapped distance; exactly half a turn stays half a turn
  assign diff      = a_r - mean_r;
  assign diff_neg  = ANGLE_BITS'(0) - diff;
  assign wrap_dist = (diff > HALF_TURN) ? diff_neg : diff;
  assign in_gate   = DW'(wrap_dist) <= DW'(thr_r);

  assign push_sum  = PW'(oldest_r) + PW'(wfill_r);
  assign push_slot = (push_sum >= PW'(WINDOW_DEPTH)) ? SW'(push_sum - PW'(WINDOW_DEPTH))
                                                     : SW'(push_sum);
  assign win_full  = wfill_r >= FW'(WINDOW_DEPTH);
  assign cand_full = cfill_r >= CF_W'(CANDIDATE_DEPTH);
  assign new_cf    = cand_full ? cfill_r : cfill_r + CF_W'(1);

  always_comb begin
    if (swc_r == '0) begin
      need = NW'(1);
    end else if (NW'(swc_r) > NW'(CANDIDATE_DEPTH)) begin
      need = NW'(CANDIDATE_DEPTH);
    end else begin
      need = NW'(swc_r);
    end
  end

  assign oldest_inc = (oldest_r == SW'(WINDOW_DEPTH - 1)) ? '0 : oldest_r + SW'(1);
  assign ws_inc     = (ws_r == SW'(WINDOW_DEPTH - 1)) ? '0 : ws_r + SW'(1);
  // only the newest WINDOW_DEPTH candidates count toward the new total
  assign keep_cand  = CW'(idx_r) + CW'(WINDOW_DEPTH) >= CW'(cfill_r);
  assign last_cand  = CW'(idx_r) + CW'(1) == CW'(cfill_r);
  assign cf_ge_wd   = CW'(cfill_r) >= CW'(WINDOW_DEPTH);
  assign out_free   = !out_valid_r || !out_stall;

  assign cand_we   = (state_r == S_EVAL) && (wfill_r != '0) && !in_gate && !cand_full;
  assign div_start = (state_r == S_DIV_GO);

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    mean_nxt      = mean_r;
    wfill_nxt     = wfill_r;
    oldest_nxt    = oldest_r;
    total_nxt     = total_r;
    cfill_nxt     = cfill_r;
    idx_nxt       = idx_r;
    ws_nxt        = ws_r;
    thr_nxt       = thr_r;
    swc_nxt       = swc_r;
    oc_nxt        = oc_r;
    out_mean_nxt  = out_mean_r;
    out_oc_nxt    = out_oc_r;
    out_valid_nxt = out_valid_r && out_stall;
    win_we        = 1'b0;
    win_waddr     = push_slot;
    win_wdata     = a_r;

    if (cfg_wr_en) begin
      unique case (cfg_index)
        ajgma_pkg::CFG_JUMP_THRESHOLD: thr_nxt = cfg_data;
        ajgma_pkg::CFG_SWITCH_COUNT:   swc_nxt = cfg_data[ajgma_pkg::SWC_W-1:0];
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          a_nxt     = in_angle_in;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (wfill_r == '0) begin
          win_we    = 1'b1;
          wfill_nxt = FW'(1);
          total_nxt = TOT_W'(a_r);
          mean_nxt  = a_r;
          oc_nxt    = ajgma_pkg::OC_FIRST;
          state_nxt = S_RESULT;
        end else if (in_gate) begin
          cfill_nxt = '0;
          oc_nxt    = ajgma_pkg::OC_ACCEPT;
          if (win_full) begin
            state_nxt = S_EVICT;
          end else begin
            win_we    = 1'b1;
            wfill_nxt = wfill_r + FW'(1);
            total_nxt = total_r + TOT_W'(a_r);
            state_nxt = S_DIV_GO;
          end
        end else begin
          cfill_nxt = new_cf;
          if (NW'(new_cf) >= need) begin
            wfill_nxt  = '0;
            oldest_nxt = '0;
            total_nxt  = '0;
            idx_nxt    = '0;
            ws_nxt     = '0;
            oc_nxt     = ajgma_pkg::OC_SWITCH;
            state_nxt  = S_SW_RD;
          end else begin
            oc_nxt    = ajgma_pkg::OC_HOLD;
            state_nxt = S_RESULT;
          end
        end
      end
      S_EVICT: begin
        // win_q holds the oldest entry, read during the evaluate cycle
        win_we     = 1'b1;
        win_waddr  = oldest_r;
        total_nxt  = total_r - TOT_W'(win_q) + TOT_W'(a_r);
        oldest_nxt = oldest_inc;
        state_nxt  = S_DIV_GO;
      end
      S_SW_RD: begin
        state_nxt = S_SW_WR;
      end
      S_SW_WR: begin
        win_we    = 1'b1;
        win_waddr = ws_r;
        win_wdata = cand_q;
        ws_nxt    = ws_inc;
        if (keep_cand) begin
          total_nxt = total_r + TOT_W'(cand_q);
        end
        if (last_cand) begin
          wfill_nxt  = cf_ge_wd ? FW'(WINDOW_DEPTH) : FW'(cfill_r);
          oldest_nxt = cf_ge_wd ? ws_inc : '0;
          cfill_nxt  = '0;
          state_nxt  = S_DIV_GO;
        end else begin
          idx_nxt   = idx_r + CIW'(1);
          state_nxt = S_SW_RD;
        end
      end
      S_DIV_GO: begin
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          mean_nxt  = ANGLE_BITS'(div_quot);
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt  = ajgma_pkg::SMOOTH_W'(mean_r);
          out_oc_nxt    = oc_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mean_r      <= '0;
      wfill_r     <= '0;
      oldest_r    <= '0;
      total_r     <= '0;
      cfill_r     <= '0;
      idx_r       <= '0;
      ws_r        <= '0;
      thr_r       <= ajgma_pkg::THR_RESET;
      swc_r       <= ajgma_pkg::SWC_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mean_r      <= mean_nxt;
      wfill_r     <= wfill_nxt;
      oldest_r    <= oldest_nxt;
      total_r     <= total_nxt;
      cfill_r     <= cfill_nxt;
      idx_r       <= idx_nxt;
      ws_r        <= ws_nxt;
      thr_r       <= thr_nxt;
      swc_r       <= swc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r        <= a_nxt;
    oc_r       <= oc_nxt;
    out_mean_r <= out_mean_nxt;
    out_oc_r   <= out_oc_nxt;
  end

  ajgma_ram #(
    .DEPTH (WINDOW_DEPTH),
    .WIDTH (ANGLE_BITS)
  ) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata (win_wdata),
    .raddr (oldest_r),
    .rdata (win_q)
  );

  ajgma_ram #(
    .DEPTH (CANDIDATE_DEPTH),
    .WIDTH (ANGLE_BITS)
  ) u_cand_ram (
    .clk   (clk),
    .we    (cand_we),
    .waddr (cfill_r[CIW-1:0]),
    .wdata (a_r),
    .raddr (idx_r),
    .rdata (cand_q)
  );

  ajgma_div #(
    .DVD_W (TOT_W),
    .DVS_W (FW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (total_r),
    .divisor  (wfill_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign in_stall           = !rst_n || (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_smoothed_angle = out_mean_r;
  assign out_outcome        = out_oc_r;

endmodule

### hdl/ajgma_checker.sv
// Port-level checker for the angle smoother, bound to the top level.
module ajgma_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [ajgma_pkg::SMOOTH_W-1:0]  out_smoothed_angle,
  input logic [ajgma_pkg::OUTCOME_W-1:0] out_outcome
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_smoothed_angle) && $stable(out_outcome))
    else $error("stalled result changed");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while first is at work");

  // a fresh result only comes out of a busy cycle
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item at work");

endmodule

bind angle_jump_gated_moving_average ajgma_checker u_ajgma_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_smoothed_angle (out_smoothed_angle),
  .out_outcome        (out_outcome)
);
